>>> rtl/core/lap3_pkg.sv
// shared types and constants for the 3x3 laplacian pixel filter
// no dependencies; every other file in rtl/core refers to it by scoped names

package lap3_pkg;

    // field widths
    localparam int PIX_W  = 8;
    localparam int POS_W  = 11;
    localparam int CFG_W  = 12;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    // result queue sizing: one item can cause up to three results
    localparam int RES_MAX    = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    // register reset values
    localparam int unsigned RESET_WIDTH  = 640;
    localparam int unsigned RESET_HEIGHT = 480;

    // register indexes (word address bits)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ALPHA  = 2'd2;

    // stored pixel, packed as B | G<<8 | R<<16 | A<<24
    typedef struct packed {
        logic [PIX_W-1:0] alpha;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pix_t;

    // per-item schedule decided at accept time
    typedef struct packed {
        logic             emit_a;    // pixel one row up, one column left
        logic             emit_b;    // right border pixel of the row above
        logic             emit_c;    // pixel itself on the bottom row
        logic             interior;  // emit_a pixel gets the kernel
        logic             last_col;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } sched_t;

    // one result beat
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] alpha;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } result_t;

endpackage

>>> rtl/core/lap3_pix_if.sv
// input pixel channel: valid/ready handshake with one BGRA pixel per beat
// depends on lap3_pkg for the byte width

interface lap3_pix_if;
    logic                      valid;
    logic                      ready;
    logic [lap3_pkg::PIX_W-1:0] blue_in;
    logic [lap3_pkg::PIX_W-1:0] green_in;
    logic [lap3_pkg::PIX_W-1:0] red_in;
    logic [lap3_pkg::PIX_W-1:0] alpha_in;

    modport source (output valid, blue_in, green_in, red_in, alpha_in, input ready);
    modport sink   (input valid, blue_in, green_in, red_in, alpha_in, output ready);
endinterface

>>> rtl/core/lap3_res_if.sv
// result channel: valid/ready handshake with one filtered pixel and its position per beat
// depends on lap3_pkg for the field widths

interface lap3_res_if;
    logic                      valid;
    logic                      ready;
    logic [lap3_pkg::PIX_W-1:0] blue_out;
    logic [lap3_pkg::PIX_W-1:0] green_out;
    logic [lap3_pkg::PIX_W-1:0] red_out;
    logic [lap3_pkg::PIX_W-1:0] alpha_out;
    logic [lap3_pkg::POS_W-1:0] out_row;
    logic [lap3_pkg::POS_W-1:0] out_col;
    logic                      last_pixel;

    modport source (output valid, blue_out, green_out, red_out, alpha_out,
                    out_row, out_col, last_pixel, input ready);
    modport sink   (input valid, blue_out, green_out, red_out, alpha_out,
                    out_row, out_col, last_pixel, output ready);
endinterface

>>> rtl/core/lap3_line_mem.sv
// two line stores in one synchronous ram: upper row in the high word, middle row in the low word
// registered read, with forwarding of a same-address write in the read cycle; uses lap3_pkg

module lap3_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [2*lap3_pkg::DATA_W-1:0] wr_data,
    output logic [2*lap3_pkg::DATA_W-1:0] rd_data
);

    localparam int LW = 2 * lap3_pkg::DATA_W;

    logic [LW-1:0] mem [DEPTH];
    logic [LW-1:0] rd_data_reg;
    logic [LW-1:0] fwd_data_reg;
    logic          fwd_reg;

    // ram array, read-first
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // capture write data in case the read hit the entry being written
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // forward select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

>>> rtl/core/lap3_window.sv
// 3x3 window: two stored columns plus the column from the line stores and the new pixel
// computes the kernel and the up to three result beats of an item; uses lap3_pkg

module lap3_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  lap3_pkg::sched_t            sched,
    input  lap3_pkg::pix_t              cur,
    input  lap3_pkg::pix_t              up,
    input  lap3_pkg::pix_t              mid,
    input  logic                        with_alpha,
    output lap3_pkg::result_t [2:0]     res,
    output logic [2:0]                  push
);

    localparam int PW = lap3_pkg::PIX_W;

    // 8 * centre minus the eight neighbours, clamped to 0..255
    function automatic logic [PW-1:0] kernel(input logic [PW-1:0] ctr,
                                             input logic [8*PW-1:0] nb);
        logic [PW+2:0]        sum;
        logic signed [PW+4:0] v;
        sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + (PW+3)'(nb[i*PW +: PW]);
        end
        v = $signed({2'b00, ctr, 3'b000}) - $signed({2'b00, sum});
        if (v < 0)
        begin
            return '0;
        end
        else if (v > $signed((PW+5)'(255)))
        begin
            return '1;
        end
        return v[PW-1:0];
    endfunction

    // window columns: [0..2] oldest column, [3..5] next, top to bottom
    lap3_pkg::pix_t win_reg [6];
    lap3_pkg::pix_t ctr;
    lap3_pkg::pix_t px_a;
    logic [7:0]     alpha_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up;
            win_reg[4] <= mid;
            win_reg[5] <= cur;
        end
    end

    assign ctr = win_reg[4];

    // filtered or passed centre pixel
    always_comb
    begin
        px_a = ctr;
        if (sched.interior)
        begin
            px_a.blue  = kernel(ctr.blue,  {win_reg[0].blue,  win_reg[3].blue,  up.blue,
                                            win_reg[1].blue,  mid.blue,  win_reg[2].blue,
                                            win_reg[5].blue,  cur.blue});
            px_a.green = kernel(ctr.green, {win_reg[0].green, win_reg[3].green, up.green,
                                            win_reg[1].green, mid.green, win_reg[2].green,
                                            win_reg[5].green, cur.green});
            px_a.red   = kernel(ctr.red,   {win_reg[0].red,   win_reg[3].red,   up.red,
                                            win_reg[1].red,   mid.red,   win_reg[2].red,
                                            win_reg[5].red,   cur.red});
        end
    end

    assign alpha_mask = {8{with_alpha}};

    // result beats in emission order
    always_comb
    begin
        res[0].blue  = px_a.blue;
        res[0].green = px_a.green;
        res[0].red   = px_a.red;
        res[0].alpha = px_a.alpha & alpha_mask;
        res[0].row   = sched.row - lap3_pkg::POS_W'(1);
        res[0].col   = sched.col - lap3_pkg::POS_W'(1);
        res[0].last  = 1'b0;

        res[1].blue  = mid.blue;
        res[1].green = mid.green;
        res[1].red   = mid.red;
        res[1].alpha = mid.alpha & alpha_mask;
        res[1].row   = sched.row - lap3_pkg::POS_W'(1);
        res[1].col   = sched.col;
        res[1].last  = 1'b0;

        res[2].blue  = cur.blue;
        res[2].green = cur.green;
        res[2].red   = cur.red;
        res[2].alpha = cur.alpha & alpha_mask;
        res[2].row   = sched.row;
        res[2].col   = sched.col;
        res[2].last  = sched.last_col;
    end

    assign push = {sched.emit_c, sched.emit_b, sched.emit_a} & {3{step}};

endmodule

>>> rtl/core/lap3_result_fifo.sv
// result queue: takes up to three beats per cycle, hands out one per cycle while not empty
// and the channel is ready; drives the result channel directly; uses lap3_pkg and lap3_res_if

module lap3_result_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [2:0]                          push,
    input  lap3_pkg::result_t [2:0]             push_data,
    output logic [lap3_pkg::FIFO_CW-1:0]        count,
    lap3_res_if.source                          result
);

    localparam int AW = lap3_pkg::FIFO_AW;
    localparam int CW = lap3_pkg::FIFO_CW;

    lap3_pkg::result_t entry_reg [lap3_pkg::FIFO_DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic [AW-1:0]     slot_addr [3];
    logic [AW-1:0]     n_push;
    logic              pop;
    lap3_pkg::result_t head;

    // compact the pushed beats onto consecutive slots
    always_comb
    begin
        n_push = '0;
        for (int i = 0; i < 3; i++)
        begin
            slot_addr[i] = wr_ptr_reg + n_push;
            if (push[i])
            begin
                n_push = n_push + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (push[i])
            begin
                entry_reg[slot_addr[i]] <= push_data[i];
            end
        end
    end

    assign pop         = result.valid && result.ready;
    assign wr_ptr_next = wr_ptr_reg + n_push;
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + CW'(n_push) - CW'(pop);

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // head of queue onto the channel
    assign head              = entry_reg[rd_ptr_reg];
    assign result.valid      = (count_reg != '0);
    assign result.blue_out   = head.blue;
    assign result.green_out  = head.green;
    assign result.red_out    = head.red;
    assign result.alpha_out  = head.alpha;
    assign result.out_row    = head.row;
    assign result.out_col    = head.col;
    assign result.last_pixel = head.last;
    assign count             = count_reg;

endmodule

>>> rtl/core/laplacian_3x3_rgb_filter.sv
// top level of the streaming 3x3 eight-neighbor laplacian filter with apb register port
// depends on lap3_pkg, lap3_pix_if, lap3_res_if, lap3_line_mem, lap3_window, lap3_result_fifo
//
//   port     dir  handshake             beat
//   pixel    in   valid/ready           one BGRA pixel in raster order
//   result   out  valid/ready           one pixel with row, col and last flag
//   apb      in   psel/penable/pwrite   register write or read, pready tied high
//
// one pixel per clock is taken while the queue has room; items are registered in stage 1
// and their results then in an eight-beat queue, which on the bottom row (one to three beats per pixel)
// limits intake to the at most one beat per clock the result port drains.
// the line store ram is read at accept and written back in the following cycle.
// reset clears counters, pipeline and queue; line stores are not cleared.
// a write to the width, height or alpha register restarts the image at row 0, column 0.

module laplacian_3x3_rgb_filter #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lap3_pix_if.sink                      pixel,
    lap3_res_if.source                    result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lap3_pkg::ADDR_W-1:0]   paddr,
    input  logic [lap3_pkg::DATA_W-1:0]   pwdata,
    output logic [lap3_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CW    = lap3_pkg::CFG_W;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WD_W  = ($clog2(MAX_WIDTH + 1) > CW) ? $clog2(MAX_WIDTH + 1) : CW;
    localparam int HD_W  = ($clog2(MAX_HEIGHT + 1) > CW) ? $clog2(MAX_HEIGHT + 1) : CW;
    localparam int QW    = lap3_pkg::FIFO_CW + 1;

    // configuration registers
    logic [CW-1:0] width_reg;
    logic [CW-1:0] height_reg;
    logic          alpha_reg;
    logic          cfg_wr;
    logic          cfg_hit;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lap3_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            lap3_pkg::REG_WIDTH:  cfg_hit = cfg_wr;
            lap3_pkg::REG_HEIGHT: cfg_hit = cfg_wr;
            lap3_pkg::REG_ALPHA:  cfg_hit = cfg_wr;
            default:              cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CW'(lap3_pkg::RESET_WIDTH);
            height_reg <= CW'(lap3_pkg::RESET_HEIGHT);
            alpha_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                lap3_pkg::REG_WIDTH:  width_reg  <= pwdata[CW-1:0];
                lap3_pkg::REG_HEIGHT: height_reg <= pwdata[CW-1:0];
                lap3_pkg::REG_ALPHA:  alpha_reg  <= pwdata[0];
                default:              ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            lap3_pkg::REG_WIDTH:  prdata = lap3_pkg::DATA_W'(width_reg);
            lap3_pkg::REG_HEIGHT: prdata = lap3_pkg::DATA_W'(height_reg);
            lap3_pkg::REG_ALPHA:  prdata = lap3_pkg::DATA_W'(alpha_reg);
            default:              prdata = '0;
        endcase
    end

    // effective image size: zero acts as one, clipped to MAX_WIDTH and MAX_HEIGHT
    logic [WD_W-1:0] width_ext,  eff_w;
    logic [HD_W-1:0] height_ext, eff_h;

    assign width_ext  = WD_W'(width_reg);
    assign height_ext = HD_W'(height_reg);
    assign eff_w = (width_ext == '0) ? WD_W'(1) :
                   (width_ext > WD_W'(MAX_WIDTH)) ? WD_W'(MAX_WIDTH) : width_ext;
    assign eff_h = (height_ext == '0) ? HD_W'(1) :
                   (height_ext > HD_W'(MAX_HEIGHT)) ? HD_W'(MAX_HEIGHT) : height_ext;

    // position of the next input pixel
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             last_col, last_row;
    logic             accept;

    assign last_col = (WD_W'(col_reg) + WD_W'(1)) == eff_w;
    assign last_row = (HD_W'(row_reg) + HD_W'(1)) == eff_h;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // schedule of the item being accepted
    lap3_pkg::sched_t sched;

    always_comb
    begin
        sched.emit_a   = (row_reg != '0) && (col_reg != '0);
        sched.emit_b   = (row_reg != '0) && last_col;
        sched.emit_c   = last_row;
        sched.interior = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        sched.last_col = last_col;
        sched.row      = lap3_pkg::POS_W'(row_reg);
        sched.col      = lap3_pkg::POS_W'(col_reg);
    end

    // intake credit: room for this beat's results and those of the item in flight
    logic [lap3_pkg::FIFO_CW-1:0] q_count;
    logic                         s1_valid_reg;
    logic [QW-1:0]                q_need;

    assign q_need      = QW'(q_count) + (s1_valid_reg ? QW'(lap3_pkg::RES_MAX) : QW'(0));
    assign pixel.ready = q_need <= QW'(lap3_pkg::FIFO_DEPTH - lap3_pkg::RES_MAX);
    assign accept      = pixel.valid && pixel.ready;

    // stage 1: item waiting for its line store read
    lap3_pkg::pix_t   in_pix;
    lap3_pkg::pix_t   s1_pix_reg;
    lap3_pkg::sched_t s1_sched_reg;
    logic [COL_W-1:0] s1_col_reg;

    always_comb
    begin
        in_pix.blue  = pixel.blue_in;
        in_pix.green = pixel.green_in;
        in_pix.red   = pixel.red_in;
        in_pix.alpha = pixel.alpha_in;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= in_pix;
            s1_sched_reg <= sched;
            s1_col_reg   <= col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // line stores: read at accept, shift down by one row at write back
    logic [2*lap3_pkg::DATA_W-1:0] line_rd;
    logic [2*lap3_pkg::DATA_W-1:0] line_wr;
    lap3_pkg::pix_t                up_pix;
    lap3_pkg::pix_t                mid_pix;

    assign up_pix  = line_rd[2*lap3_pkg::DATA_W-1:lap3_pkg::DATA_W];
    assign mid_pix = line_rd[lap3_pkg::DATA_W-1:0];
    assign line_wr = {mid_pix, s1_pix_reg};

    lap3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    // window and kernel
    lap3_pkg::result_t [2:0] res;
    logic [2:0]              push;

    lap3_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_valid_reg),
        .sched      (s1_sched_reg),
        .cur        (s1_pix_reg),
        .up         (up_pix),
        .mid        (mid_pix),
        .with_alpha (alpha_reg),
        .res        (res),
        .push       (push)
    );

    // result queue
    lap3_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .count     (q_count),
        .result    (result)
    );

    // queue never overfills under the intake credit
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= lap3_pkg::FIFO_CW'(lap3_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // intake only stalls when results are backed up
    assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (q_count != '0))
        else $error("intake stalled with an empty result queue");

    // queue grows by at most one item's worth of results per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        QW'(q_count) <= QW'($past(q_count)) + QW'(lap3_pkg::RES_MAX))
        else $error("result queue grew faster than one item per cycle");

endmodule
